// ===== rtl/ray_unit_sphere_intersect_assert.svh =====
// ----------------------------------------------------------------------------
// Ray versus unit sphere: assertion macros
// Concurrent checks on the rising clock edge, idle while reset is held.
// ----------------------------------------------------------------------------
`ifndef RAY_UNIT_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_UNIT_SPHERE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RUSI_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RUSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rusi_pkg.sv =====
// ----------------------------------------------------------------------------
// rusi_pkg
// Shared constants of the ray versus unit sphere intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package rusi_pkg;

  localparam int CRD_W         = 32;
  localparam int QUOT_W        = CRD_W - 1;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MIN_DIST_W    = 16;
  localparam logic [MIN_DIST_W-1:0] MIN_DIST_RST = 16'd66;

endpackage

`default_nettype wire

// ===== rtl/rusi_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rusi_sqrt_cell
// One bit of a pipelined integer square root: shift in two radicand bits,
// trial subtract, register root, remainder and the riding payload.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_sqrt_cell #(
  parameter int SQW = 51,
  parameter int PLW = 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic [2*SQW-1:0]   rad_i,
  input  wire logic [SQW+2:0]     rem_i,
  input  wire logic [SQW-1:0]     root_i,
  input  wire logic [PLW-1:0]     pl_i,
  output logic                    valid_o,
  output logic [2*SQW-1:0]        rad_o,
  output logic [SQW+2:0]          rem_o,
  output logic [SQW-1:0]          root_o,
  output logic [PLW-1:0]          pl_o
);

  localparam int RW  = 2 * SQW;
  localparam int RMW = SQW + 3;

  logic           valid_q;
  logic [RW-1:0]  rad_q,  rad_d;
  logic [RMW-1:0] rem_q,  rem_d;
  logic [SQW-1:0] root_q, root_d;
  logic [PLW-1:0] pl_q;
  logic [RMW-1:0] rem_sh, trial;
  logic           ge;

  always_comb begin
    rem_sh = {rem_i[RMW-3:0], rad_i[RW-1 -: 2]};
    trial  = RMW'({root_i, 2'b01});
    ge     = rem_sh >= trial;
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[SQW-2:0], ge};
    rad_d  = {rad_i[RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pl_q   <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pl_o    = pl_q;

endmodule

`default_nettype wire

// ===== rtl/rusi_div_cell.sv =====
// ----------------------------------------------------------------------------
// rusi_div_cell
// One quotient bit of two restoring dividers sharing a divisor: compare,
// subtract, halve the divisor and register everything with the payload.
// ----------------------------------------------------------------------------
`default_nettype none

module rusi_div_cell #(
  parameter int XW  = 82,
  parameter int QW  = 31,
  parameter int PLW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [XW-1:0]   dv_i,
  input  wire logic [XW-1:0]   rem0_i,
  input  wire logic [XW-1:0]   rem1_i,
  input  wire logic [QW-1:0]   q0_i,
  input  wire logic [QW-1:0]   q1_i,
  input  wire logic [PLW-1:0]  pl_i,
  output logic                 valid_o,
  output logic [XW-1:0]        dv_o,
  output logic [XW-1:0]        rem0_o,
  output logic [XW-1:0]        rem1_o,
  output logic [QW-1:0]        q0_o,
  output logic [QW-1:0]        q1_o,
  output logic [PLW-1:0]       pl_o
);

  logic           valid_q;
  logic [XW-1:0]  dv_q, rem0_q, rem1_q, rem0_d, rem1_d;
  logic [QW-1:0]  q0_q, q1_q;
  logic [PLW-1:0] pl_q;
  logic           ge0, ge1;

  always_comb begin
    ge0    = rem0_i >= dv_i;
    ge1    = rem1_i >= dv_i;
    rem0_d = ge0 ? (rem0_i - dv_i) : rem0_i;
    rem1_d = ge1 ? (rem1_i - dv_i) : rem1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q   <= dv_i >> 1;
      rem0_q <= rem0_d;
      rem1_q <= rem1_d;
      q0_q   <= {q0_i[QW-2:0], ge0};
      q1_q   <= {q1_i[QW-2:0], ge1};
      pl_q   <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign dv_o    = dv_q;
  assign rem0_o  = rem0_q;
  assign rem1_o  = rem1_q;
  assign q0_o    = q0_q;
  assign q1_o    = q1_q;
  assign pl_o    = pl_q;

endmodule

`default_nettype wire

// ===== rtl/ray_unit_sphere_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_unit_sphere_intersect
// Fixed point ray versus unit sphere hit test with distance and hit point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ray a beat: origin x, y, z then direction x, y, z,
//   each signed fixed point with FRAC_BITS fraction bits.
//   m_axis returns one beat for each ray, in order: tuser is the hit flag,
//   tdata the distance and the hit point x, y, z; a miss returns all zeros.
//   cfg writes the minimum hit distance; write it only while no ray is in
//   flight. It is always ready.
//   The path from input beat to output beat runs through the square root
//   cell chain (one cell per root bit) and the divider cell chain (one
//   cell per quotient bit), besides the other pipeline stages.
//   Throughput is one ray a cycle while the output is not stalled.
//   A stalled receiver holds the output register; the pipeline keeps
//   moving until its last stage is full, then input ready drops.
//   Reset empties the pipeline and restores the minimum distance to 66.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_unit_sphere_intersect_assert.svh"

module ray_unit_sphere_intersect #(
  parameter int FRAC_BITS = rusi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  wire logic [6*rusi_pkg::CRD_W-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // hit_distance, normal_x, normal_y, normal_z
  output logic [4*rusi_pkg::CRD_W-1:0]           m_axis_tdata,
  // hit
  output logic [0:0]                             m_axis_tuser,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rusi_pkg::MIN_DIST_W-1:0]   cfg_data_i
);

  localparam int CW   = rusi_pkg::CRD_W;
  localparam int PW   = 2 * CW;
  localparam int DW   = PW + 2 - FRAC_BITS;
  localparam int HW   = (DW + 1) / 2;
  localparam int SQW  = DW + 1;
  localparam int RW   = 2 * SQW;
  localparam int RMW  = SQW + 3;
  localparam int NW   = DW + 2;
  localparam int XW   = DW + CW;
  localparam int QW   = rusi_pkg::QUOT_W;
  localparam int RYW  = 6 * CW;
  localparam int SPL  = 1 + 2 * DW + RYW;
  localparam int DPL  = 5 + RYW;
  localparam int SUMW = PW + 1 - FRAC_BITS;
  localparam logic [CW-1:0] S_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] S_MIN = {1'b1, {(CW-1){1'b0}}};

  logic adv;
  logic [rusi_pkg::MIN_DIST_W-1:0] min_dist_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= rusi_pkg::MIN_DIST_RST;
    end else if (cfg_valid_i) begin
      min_dist_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic v10_q, v11_q, v12_q, v13_q, out_v_q;
  logic sq_v  [SQW+1];
  logic dv_v  [QW+1];

  // ---- S1: products
  logic signed [PW-1:0] pdd1_q [3];
  logic signed [PW-1:0] pod1_q [3];
  logic signed [PW-1:0] poo1_q [3];
  logic [RYW-1:0] ray1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pdd1_q[i] <= $signed(s_axis_tdata[(3+i)*CW +: CW])
                   * $signed(s_axis_tdata[(3+i)*CW +: CW]);
        pod1_q[i] <= $signed(s_axis_tdata[i*CW +: CW])
                   * $signed(s_axis_tdata[(3+i)*CW +: CW]);
        poo1_q[i] <= $signed(s_axis_tdata[i*CW +: CW])
                   * $signed(s_axis_tdata[i*CW +: CW]);
      end
      ray1_q <= s_axis_tdata;
    end
  end

  // ---- S2: floor-shifted dot products
  logic [DW-1:0] a2_d, h2_d, c2_d, a2_q, h2_q, c2_q;
  logic [RYW-1:0] ray2_q;

  always_comb begin
    a2_d = '0;
    h2_d = '0;
    c2_d = '0;
    for (int i = 0; i < 3; i++) begin
      a2_d = a2_d + {{2{pdd1_q[i][PW-1]}}, pdd1_q[i][PW-1:FRAC_BITS]};
      h2_d = h2_d + {{2{pod1_q[i][PW-1]}}, pod1_q[i][PW-1:FRAC_BITS]};
      c2_d = c2_d + {{2{poo1_q[i][PW-1]}}, poo1_q[i][PW-1:FRAC_BITS]};
    end
    c2_d = c2_d - (DW'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a2_q   <= a2_d;
      h2_q   <= h2_d;
      c2_q   <= c2_d;
      ray2_q <= ray1_q;
    end
  end

  // ---- S3: magnitudes and flags
  logic [DW-1:0]  mh3_q, mc3_q, a3_q, h3_q;
  logic           az3_q, cn3_q;
  logic [RYW-1:0] ray3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mh3_q  <= h2_q[DW-1] ? (DW'(0) - h2_q) : h2_q;
      mc3_q  <= c2_q[DW-1] ? (DW'(0) - c2_q) : c2_q;
      az3_q  <= a2_q == '0;
      cn3_q  <= c2_q[DW-1];
      a3_q   <= a2_q;
      h3_q   <= h2_q;
      ray3_q <= ray2_q;
    end
  end

  // ---- S4: half-width partial products of h*h and a*|c|
  logic [2*HW-1:0] hp4, ap4, cp4;
  logic [2*HW-1:0] hll4_q, hlh4_q, hhh4_q;
  logic [2*HW-1:0] all4_q, alh4_q, ahl4_q, ahh4_q;
  logic [DW-1:0]   a4_q, h4_q;
  logic            az4_q, cn4_q;
  logic [RYW-1:0]  ray4_q;

  assign hp4 = (2*HW)'(mh3_q);
  assign ap4 = (2*HW)'(a3_q);
  assign cp4 = (2*HW)'(mc3_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hll4_q <= hp4[HW-1:0]    * hp4[HW-1:0];
      hlh4_q <= hp4[HW-1:0]    * hp4[2*HW-1:HW];
      hhh4_q <= hp4[2*HW-1:HW] * hp4[2*HW-1:HW];
      all4_q <= ap4[HW-1:0]    * cp4[HW-1:0];
      alh4_q <= ap4[HW-1:0]    * cp4[2*HW-1:HW];
      ahl4_q <= ap4[2*HW-1:HW] * cp4[HW-1:0];
      ahh4_q <= ap4[2*HW-1:HW] * cp4[2*HW-1:HW];
      a4_q   <= a3_q;
      h4_q   <= h3_q;
      az4_q  <= az3_q;
      cn4_q  <= cn3_q;
      ray4_q <= ray3_q;
    end
  end

  // ---- S5: recombine partial products
  logic [RW-1:0]  hh5_q, ac5_q;
  logic [DW-1:0]  a5_q, h5_q;
  logic           az5_q, cn5_q;
  logic [RYW-1:0] ray5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hh5_q  <= RW'({hhh4_q, hll4_q}) + (RW'(hlh4_q) << (HW + 1));
      ac5_q  <= RW'({ahh4_q, all4_q}) + (RW'(alh4_q) << HW) + (RW'(ahl4_q) << HW);
      a5_q   <= a4_q;
      h5_q   <= h4_q;
      az5_q  <= az4_q;
      cn5_q  <= cn4_q;
      ray5_q <= ray4_q;
    end
  end

  // ---- S6: discriminant
  logic [RW-1:0]  disc6_q;
  logic           miss6_q;
  logic [DW-1:0]  a6_q, h6_q;
  logic [RYW-1:0] ray6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      disc6_q <= cn5_q ? (hh5_q + ac5_q) : (hh5_q - ac5_q);
      miss6_q <= az5_q | (!cn5_q & (ac5_q > hh5_q));
      a6_q    <= a5_q;
      h6_q    <= h5_q;
      ray6_q  <= ray5_q;
    end
  end

  // ---- square root cell chain
  logic [RW-1:0]  sq_rad  [SQW+1];
  logic [RMW-1:0] sq_rem  [SQW+1];
  logic [SQW-1:0] sq_root [SQW+1];
  logic [SPL-1:0] sq_pl   [SQW+1];

  assign sq_v[0]    = v6_q;
  assign sq_rad[0]  = disc6_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pl[0]   = {miss6_q, a6_q, h6_q, ray6_q};

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    rusi_sqrt_cell #(
      .SQW (SQW),
      .PLW (SPL)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[k]),
      .rad_i   (sq_rad[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .pl_i    (sq_pl[k]),
      .valid_o (sq_v[k+1]),
      .rad_o   (sq_rad[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .pl_o    (sq_pl[k+1])
    );
  end

  // ---- S7: root numerators
  logic [DW-1:0]  h7;
  logic [NW-1:0]  nh7;
  logic [NW-1:0]  n07_q, n17_q;
  logic [DW-1:0]  a7_q;
  logic           miss7_q;
  logic [RYW-1:0] ray7_q;

  assign h7  = sq_pl[SQW][RYW +: DW];
  assign nh7 = NW'(0) - {{2{h7[DW-1]}}, h7};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n07_q   <= nh7 - NW'(sq_root[SQW]);
      n17_q   <= nh7 + NW'(sq_root[SQW]);
      a7_q    <= sq_pl[SQW][RYW+DW +: DW];
      miss7_q <= sq_pl[SQW][SPL-1];
      ray7_q  <= sq_pl[SQW][RYW-1:0];
    end
  end

  // ---- S8: numerator magnitudes
  logic [NW-1:0]  m08_q, m18_q;
  logic           ng08_q, ng18_q, miss8_q;
  logic [DW-1:0]  a8_q;
  logic [RYW-1:0] ray8_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m08_q   <= n07_q[NW-1] ? (NW'(0) - n07_q) : n07_q;
      m18_q   <= n17_q[NW-1] ? (NW'(0) - n17_q) : n17_q;
      ng08_q  <= n07_q[NW-1];
      ng18_q  <= n17_q[NW-1];
      miss8_q <= miss7_q;
      a8_q    <= a7_q;
      ray8_q  <= ray7_q;
    end
  end

  // ---- S9: scaled dividends and overflow
  logic [XW-1:0]  x09, x19, alim9;
  logic [XW-1:0]  rem09_q, rem19_q, dv9_q;
  logic [DPL-1:0] pl9_q;

  assign x09   = XW'(m08_q) << FRAC_BITS;
  assign x19   = XW'(m18_q) << FRAC_BITS;
  assign alim9 = XW'(a8_q) << QW;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem09_q <= x09;
      rem19_q <= x19;
      dv9_q   <= XW'(a8_q) << (QW - 1);
      pl9_q   <= {miss8_q, ng08_q, ng18_q, x09 >= alim9, x19 >= alim9, ray8_q};
    end
  end

  // ---- divider cell chain
  logic [XW-1:0]  dv_dv   [QW+1];
  logic [XW-1:0]  dv_rem0 [QW+1];
  logic [XW-1:0]  dv_rem1 [QW+1];
  logic [QW-1:0]  dv_q0   [QW+1];
  logic [QW-1:0]  dv_q1   [QW+1];
  logic [DPL-1:0] dv_pl   [QW+1];

  assign dv_v[0]    = v9_q;
  assign dv_dv[0]   = dv9_q;
  assign dv_rem0[0] = rem09_q;
  assign dv_rem1[0] = rem19_q;
  assign dv_q0[0]   = '0;
  assign dv_q1[0]   = '0;
  assign dv_pl[0]   = pl9_q;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rusi_div_cell #(
      .XW  (XW),
      .QW  (QW),
      .PLW (DPL)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_v[k]),
      .dv_i    (dv_dv[k]),
      .rem0_i  (dv_rem0[k]),
      .rem1_i  (dv_rem1[k]),
      .q0_i    (dv_q0[k]),
      .q1_i    (dv_q1[k]),
      .pl_i    (dv_pl[k]),
      .valid_o (dv_v[k+1]),
      .dv_o    (dv_dv[k+1]),
      .rem0_o  (dv_rem0[k+1]),
      .rem1_o  (dv_rem1[k+1]),
      .q0_o    (dv_q0[k+1]),
      .q1_o    (dv_q1[k+1]),
      .pl_o    (dv_pl[k+1])
    );
  end

  // ---- S10: signed, saturated roots
  logic           miss10, ng010, ng110, ov010, ov110;
  logic [CW-1:0]  t010_q, t110_q;
  logic           miss10_q;
  logic [RYW-1:0] ray10_q;

  assign {miss10, ng010, ng110, ov010, ov110} = dv_pl[QW][DPL-1:RYW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t010_q   <= ov010 ? (ng010 ? S_MIN : S_MAX)
                        : (ng010 ? (CW'(0) - {1'b0, dv_q0[QW]}) : {1'b0, dv_q0[QW]});
      t110_q   <= ov110 ? (ng110 ? S_MIN : S_MAX)
                        : (ng110 ? (CW'(0) - {1'b0, dv_q1[QW]}) : {1'b0, dv_q1[QW]});
      miss10_q <= miss10;
      ray10_q  <= dv_pl[QW][RYW-1:0];
    end
  end

  // ---- S11: root choice against the minimum distance
  logic [CW-1:0]  lim11, tt11;
  logic [CW-1:0]  tt11_q;
  logic           hit11_q;
  logic [RYW-1:0] ray11_q;

  assign lim11 = CW'(min_dist_q);
  assign tt11  = ($signed(t010_q) > $signed(lim11)) ? t010_q : t110_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tt11_q  <= tt11;
      hit11_q <= !miss10_q && ($signed(tt11) >= $signed(lim11));
      ray11_q <= ray10_q;
    end
  end

  // ---- S12: direction times distance
  logic signed [PW-1:0] p12_q [3];
  logic [3*CW-1:0]      o12_q;
  logic [CW-1:0]        tt12_q;
  logic                 hit12_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p12_q[i] <= $signed(ray11_q[(3+i)*CW +: CW]) * $signed(tt11_q);
      end
      o12_q   <= ray11_q[3*CW-1:0];
      tt12_q  <= tt11_q;
      hit12_q <= hit11_q;
    end
  end

  // ---- S13: hit point, saturate, zero a miss
  logic [SUMW-1:0] sum13 [3];
  logic [CW-1:0]   pt13  [3];
  logic [4*CW-1:0] dat13_q;
  logic            hit13_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum13[i] = {{(SUMW-CW){o12_q[i*CW+CW-1]}}, o12_q[i*CW +: CW]}
               + {p12_q[i][PW-1], p12_q[i][PW-1:FRAC_BITS]};
      if ((&sum13[i][SUMW-1:CW-1]) || !(|sum13[i][SUMW-1:CW-1])) begin
        pt13[i] = sum13[i][CW-1:0];
      end else begin
        pt13[i] = sum13[i][SUMW-1] ? S_MIN : S_MAX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dat13_q <= hit12_q ? {pt13[2], pt13[1], pt13[0], tt12_q} : '0;
      hit13_q <= hit12_q;
    end
  end

  // ---- output register and flow control
  logic            out_hold;
  logic [4*CW-1:0] out_dat_q;
  logic            out_hit_q;

  assign out_hold = out_v_q && !m_axis_tready;
  assign adv      = !v13_q || !out_hold;

  always_ff @(posedge clk_i) begin
    if (!out_hold) begin
      out_dat_q <= dat13_q;
      out_hit_q <= hit13_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      v8_q    <= 1'b0;
      v9_q    <= 1'b0;
      v10_q   <= 1'b0;
      v11_q   <= 1'b0;
      v12_q   <= 1'b0;
      v13_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q  <= s_axis_tvalid;
        v2_q  <= v1_q;
        v3_q  <= v2_q;
        v4_q  <= v3_q;
        v5_q  <= v4_q;
        v6_q  <= v5_q;
        v7_q  <= sq_v[SQW];
        v8_q  <= v7_q;
        v9_q  <= v8_q;
        v10_q <= dv_v[QW];
        v11_q <= v10_q;
        v12_q <= v11_q;
        v13_q <= v12_q;
      end
      out_v_q <= out_hold ? 1'b1 : v13_q;
    end
  end

  assign s_axis_tready   = adv;
  assign m_axis_tvalid   = out_v_q;
  assign m_axis_tdata    = out_dat_q;
  assign m_axis_tuser[0] = out_hit_q;

  `RUSI_ASSERT_HOLDS(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss beat carries nonzero data")
  `RUSI_ASSERT_HOLDS(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output stall")
  `RUSI_ASSERT_NEXT(a_drain, v13_q && adv, m_axis_tvalid, "finished ray lost before output")

endmodule

`default_nettype wire
